// ===== src/tsl_pkg.sv =====
// Shared types, codes and constants for the tempo-synced LFO.
// Holds the quarter-sine table, built at elaboration from a fixed Q30 polynomial.
// No dependencies.
package tsl_pkg;

  localparam int PHASE_W = 32;
  localparam int LEVEL_W = 16;
  localparam int ROM_DEPTH = 256;
  localparam int ROM_AW = 8;
  localparam int MAX_RATIO = 32;
  localparam int RATIO_W = 6;
  localparam int NUM_W = 54;
  localparam int DEN_W = 27;
  localparam int DIV_CNT_W = 6;
  localparam int WAVE_W = 18;

  localparam logic [PHASE_W-1:0] STEP_RESET = 32'd1367131;
  localparam logic [5:0] SECONDS_PER_MIN = 6'd60;

  localparam logic [2:0] REG_ENABLED = 3'd0;
  localparam logic [2:0] REG_WAVE    = 3'd1;
  localparam logic [2:0] REG_MUL     = 3'd2;
  localparam logic [2:0] REG_DIV     = 3'd3;
  localparam logic [2:0] REG_OFFSET  = 3'd4;
  localparam logic [2:0] REG_MIN     = 3'd5;
  localparam logic [2:0] REG_MAX     = 3'd6;
  localparam logic [2:0] REG_TICK    = 3'd7;

  localparam logic [2:0] WAVE_SINE = 3'd0;
  localparam logic [2:0] WAVE_TRI  = 3'd1;
  localparam logic [2:0] WAVE_SQR  = 3'd2;
  localparam logic [2:0] WAVE_SAW  = 3'd3;
  localparam logic [2:0] WAVE_ISAW = 3'd4;
  localparam logic [2:0] NUM_WAVES = 3'd5;

  typedef struct packed {
    logic                enabled;
    logic [2:0]          wave_type;
    logic [RATIO_W-1:0]  mul;
    logic [RATIO_W-1:0]  dv;
    logic [15:0]         phase_offset;
    logic [LEVEL_W-1:0]  min_level;
    logic [LEVEL_W-1:0]  max_level;
    logic [15:0]         tick_rate;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_load;
    logic apply;
    logic wave;
    logic scale;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

  typedef logic [LEVEL_W-1:0] sine_rom_t [ROM_DEPTH];

  localparam longint SINE_COEF [5] = '{
    64'sd1686629713, -64'sd693598669, 64'sd85569306, -64'sd5026995, 64'sd172271
  };

  function automatic longint mul_q30(longint a, longint b);
    longint ua;
    longint ub;
    longint p;
    logic   neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = (ua * ub) >>> 30;
    return neg ? -p : p;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint x;
    longint x2;
    longint t;
    longint v;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      x = (longint'(2 * i + 1) <<< 29) >>> ROM_AW;
      x2 = mul_q30(x, x);
      t = SINE_COEF[4];
      for (int k = 3; k >= 0; k--) begin
        t = SINE_COEF[k] + mul_q30(t, x2);
      end
      t = mul_q30(t, x);
      if (t < 0) t = 0;
      v = (t * 65536 + (64'sd1 <<< 29)) >>> 30;
      rom[i] = (v > 65535) ? 16'hFFFF : v[15:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== src/tsl_regs.sv =====
// Configuration register file of the tempo-synced LFO.
// Ratios and tick rate are limited at write time. Depends on tsl_pkg.
module tsl_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [15:0]      wr_data,
  output tsl_pkg::cfg_t    cfg
);

  localparam int RATIO_W_L = tsl_pkg::RATIO_W;

  tsl_pkg::cfg_t cfg_next;
  logic [RATIO_W_L-1:0] ratio_val;

  // Zero reads as one, anything past the limit as the limit.
  always_comb begin
    if (wr_data == 16'd0) begin
      ratio_val = RATIO_W_L'(1);
    end else if (wr_data > 16'(tsl_pkg::MAX_RATIO)) begin
      ratio_val = RATIO_W_L'(tsl_pkg::MAX_RATIO);
    end else begin
      ratio_val = wr_data[RATIO_W_L-1:0];
    end
  end

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      case (wr_index)
        tsl_pkg::REG_ENABLED: cfg_next.enabled = wr_data[0];
        tsl_pkg::REG_WAVE: begin
          if (wr_data[2:0] < tsl_pkg::NUM_WAVES) cfg_next.wave_type = wr_data[2:0];
        end
        tsl_pkg::REG_MUL:    cfg_next.mul = ratio_val;
        tsl_pkg::REG_DIV:    cfg_next.dv = ratio_val;
        tsl_pkg::REG_OFFSET: cfg_next.phase_offset = wr_data;
        tsl_pkg::REG_MIN:    cfg_next.min_level = wr_data;
        tsl_pkg::REG_MAX:    cfg_next.max_level = wr_data;
        tsl_pkg::REG_TICK:   cfg_next.tick_rate = (wr_data == 16'd0) ? 16'd1 : wr_data;
        default: cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled      <= 1'b1;
      cfg.wave_type    <= tsl_pkg::WAVE_SINE;
      cfg.mul          <= RATIO_W_L'(1);
      cfg.dv           <= RATIO_W_L'(2);
      cfg.phase_offset <= 16'd0;
      cfg.min_level    <= 16'd0;
      cfg.max_level    <= 16'hFFFF;
      cfg.tick_rate    <= 16'd750;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== src/tsl_divider.sv =====
// Restoring shift-and-subtract divider, one quotient bit per cycle.
// Keeps the low PHASE_W quotient bits. Depends on tsl_pkg.
module tsl_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [tsl_pkg::NUM_W-1:0]       num,
  input  logic [tsl_pkg::DEN_W-1:0]       den,
  output logic                            last,
  output logic [tsl_pkg::PHASE_W-1:0]     quo
);

  logic                           busy;
  logic [tsl_pkg::DIV_CNT_W-1:0]  cnt;
  logic [tsl_pkg::DEN_W-1:0]      rem;
  logic [tsl_pkg::NUM_W-1:0]      numr;
  logic [tsl_pkg::DEN_W:0]        trial;
  logic                           fits;

  assign trial = {rem, numr[tsl_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign last  = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= tsl_pkg::DIV_CNT_W'(tsl_pkg::NUM_W - 1);
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      else cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= '0;
      numr <= num;
      quo  <= '0;
    end else if (busy) begin
      rem  <= fits ? tsl_pkg::DEN_W'(trial - {1'b0, den}) : trial[tsl_pkg::DEN_W-1:0];
      numr <= {numr[tsl_pkg::NUM_W-2:0], 1'b0};
      quo  <= {quo[tsl_pkg::PHASE_W-2:0], fits};
    end
  end

endmodule

// ===== src/tsl_datapath.sv =====
// Datapath of the tempo-synced LFO: operand setup, divider, phase, wave and scaling.
// Driven by tsl_ctrl commands. Depends on tsl_pkg and tsl_divider.
module tsl_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  tsl_pkg::cmd_t                  cmd,
  output tsl_pkg::status_t               status,
  input  tsl_pkg::cfg_t                  cfg,
  input  logic                           playing,
  input  logic [31:0]                    beat_position,
  input  logic [17:0]                    tempo_bpm,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tsl_pkg::LEVEL_W-1:0]    level
);

  localparam int PW = tsl_pkg::PHASE_W;
  localparam int LW = tsl_pkg::LEVEL_W;
  localparam int WW = tsl_pkg::WAVE_W;

  logic                          play_r;
  logic [31:0]                   beat_r;
  logic [17:0]                   bpm_r;
  logic [tsl_pkg::NUM_W-1:0]     num_r;
  logic [tsl_pkg::DEN_W-1:0]     den_r;
  logic [PW-1:0]                 quo;
  logic                          div_last;
  logic [PW-1:0]                 phase_acc;
  logic [PW-1:0]                 phase_step;
  logic [WW-1:0]                 t_r;
  logic [WW+LW-1:0]              prod_r;
  logic                          up_r;

  logic [37:0]                   beat_mul;
  logic [23:0]                   bpm_mul;
  logic [11:0]                   den60;
  logic [27:0]                   den_full;
  logic [15:0]                   f;
  logic [1:0]                    quad;
  logic [tsl_pkg::ROM_AW-1:0]    idx;
  logic signed [WW:0]            w;
  logic signed [WW:0]            s;
  logic [LW-1:0]                 diff;
  logic [LW:0]                   q;
  logic [LW:0]                   x;
  logic [LW-1:0]                 level_next;

  tsl_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .load (cmd.div_load),
    .num  (num_r),
    .den  (den_r),
    .last (div_last),
    .quo  (quo)
  );

  assign beat_mul = beat_r * cfg.mul;
  assign bpm_mul  = bpm_r * cfg.mul;
  assign den60    = tsl_pkg::SECONDS_PER_MIN * cfg.dv;
  assign den_full = den60 * cfg.tick_rate;

  assign f    = phase_acc[PW-1 -: 16];
  assign quad = phase_acc[PW-1 -: 2];

  always_comb begin
    idx = phase_acc[PW-3 -: tsl_pkg::ROM_AW];
    if (quad[0]) idx = ~idx;
    s = (WW+1)'(tsl_pkg::SINE_ROM[idx]);
    case (cfg.wave_type)
      tsl_pkg::WAVE_TRI: begin
        if (f < 16'd16384) w = (WW+1)'({f, 2'b00});
        else if (f < 16'd49152) w = (WW+1)'(65536) - (WW+1)'({f - 16'd16384, 2'b00});
        else w = -(WW+1)'(65536) + (WW+1)'({f - 16'd49152, 2'b00});
      end
      tsl_pkg::WAVE_SQR: begin
        w = (quad == 2'd0 || quad == 2'd3) ? (WW+1)'(65536) : -(WW+1)'(65536);
      end
      tsl_pkg::WAVE_SAW: begin
        if (!f[15]) w = (WW+1)'({f, 1'b0});
        else w = -(WW+1)'(65536) + (WW+1)'({f[14:0], 1'b0});
      end
      tsl_pkg::WAVE_ISAW: begin
        if (!f[15]) w = -(WW+1)'({f, 1'b0});
        else w = (WW+1)'(65536) - (WW+1)'({f[14:0], 1'b0});
      end
      default: w = quad[1] ? -s : s;
    endcase
  end

  assign diff = (cfg.max_level >= cfg.min_level) ? cfg.max_level - cfg.min_level
                                                 : cfg.min_level - cfg.max_level;

  // Scale onto the span, then clamp as written even when min is above max.
  always_comb begin
    q = prod_r[WW+LW-1 -: LW+1];
    x = up_r ? {1'b0, cfg.min_level} + q : {1'b0, cfg.min_level} - q;
    if (x < {1'b0, cfg.min_level}) level_next = cfg.min_level;
    else if (x > {1'b0, cfg.max_level}) level_next = cfg.max_level;
    else level_next = x[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      play_r <= playing;
      beat_r <= beat_position;
      bpm_r  <= tempo_bpm;
    end
    if (cmd.prep) begin
      if (play_r) begin
        num_r <= tsl_pkg::NUM_W'({beat_mul, 16'd0});
        den_r <= tsl_pkg::DEN_W'(cfg.dv);
      end else begin
        num_r <= tsl_pkg::NUM_W'({bpm_mul, 24'd0});
        den_r <= den_full[tsl_pkg::DEN_W-1:0];
      end
    end
    if (cmd.wave) t_r <= WW'(w + (WW+1)'(65536));
    if (cmd.scale) begin
      prod_r <= t_r * diff;
      up_r   <= cfg.max_level >= cfg.min_level;
    end
    if (cmd.emit) level <= level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      phase_step <= tsl_pkg::STEP_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.apply) begin
        if (play_r) phase_acc <= quo + {cfg.phase_offset, 16'd0};
        else phase_step <= quo;
      end else if (cmd.emit) begin
        phase_acc <= phase_acc + phase_step;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  assign status.div_last = div_last;
  assign status.out_free = !out_valid || !out_stall;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid && level == $past(level_next))
    else $error("result not registered on emit");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && !cmd.emit |=> out_valid && $stable(level))
    else $error("pending result lost");
  a_apply_phase: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && !play_r |=> phase_step == $past(quo))
    else $error("step not taken from divider");

endmodule

// ===== src/tsl_ctrl.sv =====
// Sequencer of the tempo-synced LFO: accepts a tick, runs setup, divide, apply, wave,
// scale and emit steps. Depends on tsl_pkg.
module tsl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               enabled,
  input  tsl_pkg::status_t   status,
  output tsl_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_WAVE  = 3'd5;
  localparam logic [2:0] S_SCALE = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        // drop the beat while disabled
        if (accept && enabled) begin
          cmd.capture = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_last) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_WAVE;
      end
      S_WAVE: begin
        cmd.wave = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("emit while output occupied");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && status.div_last |=> state == S_APPLY)
    else $error("divide end missed");
  a_disabled: assert property (@(posedge clk) disable iff (rst)
    accept && !enabled |=> state == S_IDLE)
    else $error("disabled beat started work");

endmodule

// ===== src/tempo_synced_lfo_top.sv =====
// Tempo-synced LFO: one tick beat in, at most one level beat out. An enabled tick
// passes through setup, the serial divider, which produces one quotient bit per cycle
// over a 54-bit dividend, then phase, wave, scale and emit; the next tick can be taken
// in the cycle after the emit. A disabled tick is taken and gives nothing.
// A new tick is taken while a result waits.
// Depends on tsl_pkg, tsl_regs, tsl_ctrl and tsl_datapath.
module tempo_synced_lfo_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         playing,
  input  logic [31:0]  beat_position,
  input  logic [17:0]  tempo_bpm,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [15:0]  level,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  tsl_pkg::cfg_t    cfg;
  tsl_pkg::cmd_t    cmd;
  tsl_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tsl_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .enabled  (cfg.enabled),
    .status   (status),
    .cmd      (cmd)
  );

  tsl_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .playing       (playing),
    .beat_position (beat_position),
    .tempo_bpm     (tempo_bpm),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .level         (level)
  );

endmodule
